// ----- src/odo_pkg.sv -----
package odo_pkg;

	localparam int OPW       = 64;
	localparam int MUL_ITERS = OPW;
	localparam int DIV_ITERS = 2 * OPW;
	localparam int CNT_W     = 7;

	localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_ITERS - 1);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_ITERS - 1);

	// register indexes
	localparam logic [7:0] CFG_POLE    = 8'd0;
	localparam logic [7:0] CFG_GEAR    = 8'd1;
	localparam logic [7:0] CFG_RADIUS  = 8'd2;
	localparam logic [7:0] CFG_SPACING = 8'd3;

	localparam logic [7:0]  POLE_RST    = 8'd30;
	localparam logic [7:0]  GEAR_RST    = 8'd1;
	localparam logic [19:0] RADIUS_RST  = 20'd103000;
	localparam logic [21:0] SPACING_RST = 22'd503000;

	localparam logic [OPW-1:0] TWO_PI_Q32 = 64'd26986075409;
	localparam logic [OPW-1:0] INV_PI_Q32 = 64'd1367130551;
	localparam logic [OPW-1:0] TERA       = 64'd1000000000000;
	localparam logic [OPW-1:0] MEGA       = 64'd1000000;
	localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

	// arctangent of 2^-i as binary angle
	localparam logic [29:0] ATAN_BA [32] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
		30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
		30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
		30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
		30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
	};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL,
		ST_DIV,
		ST_STORE,
		ST_CLOAD,
		ST_CROT,
		ST_COMMIT
	} state_t;

	typedef enum logic [2:0] {
		STEP_K,
		STEP_DL,
		STEP_DR,
		STEP_TH,
		STEP_TURN,
		STEP_LIN,
		STEP_MX,
		STEP_MY
	} step_t;

	typedef struct packed {
		logic       take_upd;
		logic       take_clr;
		logic       load;
		logic       mul;
		logic       div;
		logic       store;
		logic       cload;
		logic       crot;
		logic       commit;
		step_t      step;
		logic [4:0] citer;
	} odo_cmd_t;

	typedef struct packed {
		logic upd;
		logic clr;
	} odo_status_t;

endpackage

// ----- src/odo_muldiv.sv -----
module odo_muldiv import odo_pkg::*; (
	input  logic             clk,
	input  logic             load,
	input  logic             mul_step,
	input  logic             div_step,
	input  logic [OPW-1:0]   a,
	input  logic [OPW-1:0]   b,
	input  logic [OPW-1:0]   c,
	output logic [2*OPW-1:0] p
);

	logic [2*OPW-1:0] p_q;
	logic [OPW-1:0]   b_q, c_q, r_q;
	logic [OPW:0]     acc, rs;
	logic             ge;

	// shift-add product in p_q, then restoring division of p_q by c_q in place
	always_comb begin
		acc = {1'b0, p_q[2*OPW-1:OPW]} + (p_q[0] ? {1'b0, b_q} : '0);
		rs  = {r_q, p_q[2*OPW-1]};
		ge  = rs >= {1'b0, c_q};
	end

	always_ff @(posedge clk) begin
		if (load) begin
			p_q <= {{OPW{1'b0}}, a};
			b_q <= b;
			c_q <= c;
			r_q <= '0;
		end else if (mul_step) begin
			p_q <= {acc, p_q[OPW-1:1]};
		end else if (div_step) begin
			r_q <= ge ? OPW'(rs - {1'b0, c_q}) : rs[OPW-1:0];
			p_q <= {p_q[2*OPW-2:0], ge};
		end
	end

	assign p = p_q;

endmodule

// ----- src/odo_ctrl.sv -----
module odo_ctrl import odo_pkg::*; #(
	parameter int CORDIC_STAGES = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	output logic        out_valid,
	input  logic        out_stall,
	input  odo_status_t status,
	output odo_cmd_t    cmd
);

	localparam logic [CNT_W-1:0] CORD_LAST = CNT_W'(CORDIC_STAGES - 1);

	state_t           state_q, state_d;
	step_t            step_q, step_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q;
	logic             has_div;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= STEP_K;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		has_div   = (step_q != STEP_K) && (step_q != STEP_MX) && (step_q != STEP_MY);
		state_d   = state_q;
		step_d    = step_q;
		cnt_d     = cnt_q;
		cmd       = '0;
		cmd.step  = step_q;
		cmd.citer = cnt_q[4:0];
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take_upd = status.upd;
					cmd.take_clr = status.clr;
					if (status.upd) begin
						step_d  = STEP_K;
						state_d = ST_LOAD;
					end
				end
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				cnt_d    = '0;
				state_d  = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				cnt_d   = cnt_q + 1'b1;
				if (cnt_q == MUL_LAST) begin
					cnt_d   = '0;
					state_d = has_div ? ST_DIV : ST_STORE;
				end
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				cnt_d   = cnt_q + 1'b1;
				if (cnt_q == DIV_LAST) begin
					cnt_d   = '0;
					state_d = ST_STORE;
				end
			end
			ST_STORE: begin
				cmd.store = 1'b1;
				priority if (step_q == STEP_LIN) begin
					state_d = ST_CLOAD;
				end else if (step_q == STEP_MY) begin
					state_d = ST_COMMIT;
				end else begin
					step_d  = step_t'(step_q + 3'd1);
					state_d = ST_LOAD;
				end
			end
			ST_CLOAD: begin
				cmd.cload = 1'b1;
				cnt_d     = '0;
				state_d   = ST_CROT;
			end
			ST_CROT: begin
				cmd.crot = 1'b1;
				cnt_d    = cnt_q + 1'b1;
				if (cnt_q == CORD_LAST) begin
					step_d  = STEP_MX;
					state_d = ST_LOAD;
				end
			end
			ST_COMMIT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ----- src/odo_datapath.sv -----
module odo_datapath import odo_pkg::*; #(
	parameter int POSITION_BITS = 48
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [7:0]                      cfg_index,
	input  logic [21:0]                     cfg_data,
	input  logic                            command,
	input  logic signed [31:0]              left_count,
	input  logic signed [31:0]              right_count,
	input  logic [23:0]                     elapsed_us,
	input  odo_cmd_t                        cmd,
	output odo_status_t                     status,
	output logic signed [POSITION_BITS-1:0] pos_x_um,
	output logic signed [POSITION_BITS-1:0] pos_y_um,
	output logic signed [31:0]              heading_angle,
	output logic signed [31:0]              linear_speed_umps,
	output logic signed [31:0]              turn_rate_urads
);

	localparam int PB = POSITION_BITS;
	localparam int SW = (PB > 58 ? PB : 58) + 2;
	localparam logic signed [SW-1:0] POS_HI = {{(SW-PB+1){1'b0}}, {(PB-1){1'b1}}};
	localparam logic signed [SW-1:0] POS_LO = ~POS_HI;

	function automatic logic [31:0] sat32(input logic [2*OPW-1:0] q, input logic neg);
		logic over;
		over = (|q[2*OPW-1:32]) || (neg ? (q[31:0] > 32'h8000_0000) : q[31]);
		if (neg)
			sat32 = over ? 32'h8000_0000 : -q[31:0];
		else
			sat32 = over ? 32'h7fff_ffff : q[31:0];
	endfunction

	logic [7:0]  pole_q, gear_q;
	logic [19:0] radius_q;
	logic [21:0] spacing_q;

	logic [31:0] last_l_q, last_r_q, cur_l_q, cur_r_q, head_q;
	logic signed [PB-1:0] pose_x_q, pose_y_q, out_x_q, out_y_q;
	logic [31:0] out_h_q, out_lin_q, out_turn_q;
	logic [23:0] elapsed_q;
	logic [17:0] ppr_q;
	logic [45:0] se_q;
	logic [54:0] k_q;
	logic signed [63:0] dl_q, dr_q;
	logic [31:0] dth_q, half_q, lin_q, turn_q;
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic flip_q;
	logic signed [SW-1:0] stepx_q, stepy_q;

	logic [OPW-1:0]   op_a, op_b, op_c;
	logic [2*OPW-1:0] prod;

	logic [31:0]        tl, tr, tl_mag, tr_mag, ang;
	logic signed [63:0] sum, diff;
	logic [63:0]        sum_mag, diff_mag, dmean_mag;
	logic signed [33:0] cosv, sinv, z0, xs, ys, at;
	logic [33:0]        cos_mag, sin_mag;
	logic [64:0]        qm;
	logic [65:0]        rnd;
	logic [57:0]        mv;
	logic               mv_neg, spacing_zero;
	logic signed [SW-1:0] mvs, ext_x, ext_y, sx, sy;
	logic signed [PB-1:0] new_x, new_y;

	assign status.upd = !command && (elapsed_us != 24'd0);
	assign status.clr = command;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pole_q    <= POLE_RST;
			gear_q    <= GEAR_RST;
			radius_q  <= RADIUS_RST;
			spacing_q <= SPACING_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_POLE:    pole_q    <= cfg_data[7:0];
				CFG_GEAR:    gear_q    <= cfg_data[7:0];
				CFG_RADIUS:  radius_q  <= cfg_data[19:0];
				CFG_SPACING: spacing_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		tl           = cur_l_q - last_l_q;
		tr           = cur_r_q - last_r_q;
		tl_mag       = tl[31] ? -tl : tl;
		tr_mag       = tr[31] ? -tr : tr;
		sum          = dl_q + dr_q;
		diff         = dr_q - dl_q;
		sum_mag      = sum[63] ? 64'(-sum) : 64'(sum);
		diff_mag     = diff[63] ? 64'(-diff) : 64'(diff);
		dmean_mag    = sum_mag >> 1;
		spacing_zero = (spacing_q == 22'd0);
		cosv         = flip_q ? -cx_q : cx_q;
		sinv         = flip_q ? -cy_q : cy_q;
		cos_mag      = cosv[33] ? 34'(-cosv) : 34'(cosv);
		sin_mag      = sinv[33] ? 34'(-sinv) : 34'(sinv);
	end

	always_comb begin
		op_a = '0;
		op_b = '0;
		op_c = '0;
		unique case (cmd.step)
			STEP_K: begin
				op_a = {44'd0, radius_q};
				op_b = TWO_PI_Q32;
			end
			STEP_DL: begin
				op_a = {32'd0, tl_mag};
				op_b = {9'd0, k_q};
				op_c = {22'd0, ppr_q, 24'd0};
			end
			STEP_DR: begin
				op_a = {32'd0, tr_mag};
				op_b = {9'd0, k_q};
				op_c = {22'd0, ppr_q, 24'd0};
			end
			STEP_TH: begin
				op_a = diff_mag;
				op_b = INV_PI_Q32;
				op_c = {33'd0, spacing_q, 9'd0};
			end
			STEP_TURN: begin
				op_a = diff_mag;
				op_b = TERA;
				op_c = {10'd0, se_q, 8'd0};
			end
			STEP_LIN: begin
				op_a = sum_mag;
				op_b = MEGA;
				op_c = {31'd0, elapsed_q, 9'd0};
			end
			STEP_MX: begin
				op_a = dmean_mag;
				op_b = {30'd0, cos_mag};
			end
			STEP_MY: begin
				op_a = dmean_mag;
				op_b = {30'd0, sin_mag};
			end
			default: ;
		endcase
	end

	odo_muldiv u_muldiv (
		.clk      (clk),
		.load     (cmd.load),
		.mul_step (cmd.mul),
		.div_step (cmd.div),
		.a        (op_a),
		.b        (op_b),
		.c        (op_c),
		.p        (prod)
	);

	// position step: product / 2^30, then rounded / 2^8
	always_comb begin
		qm     = prod[94:30];
		rnd    = {1'b0, qm} + 66'd128;
		mv     = rnd[65:8];
		mv_neg = sum[63] ^ ((cmd.step == STEP_MX) ? cosv[33] : sinv[33]);
		mvs    = mv_neg ? -SW'(mv) : SW'(mv);
	end

	always_comb begin
		ang  = head_q + half_q;
		z0   = {{2{ang[31]}}, ang};
		xs   = cx_q >>> cmd.citer;
		ys   = cy_q >>> cmd.citer;
		at   = {4'd0, ATAN_BA[cmd.citer]};
	end

	always_comb begin
		ext_x = {{(SW-PB){pose_x_q[PB-1]}}, pose_x_q};
		ext_y = {{(SW-PB){pose_y_q[PB-1]}}, pose_y_q};
		sx    = ext_x + stepx_q;
		sy    = ext_y + stepy_q;
		priority if (sx > POS_HI) new_x = POS_HI[PB-1:0];
		else if (sx < POS_LO)    new_x = POS_LO[PB-1:0];
		else                     new_x = sx[PB-1:0];
		priority if (sy > POS_HI) new_y = POS_HI[PB-1:0];
		else if (sy < POS_LO)    new_y = POS_LO[PB-1:0];
		else                     new_y = sy[PB-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.take_upd) begin
			cur_l_q   <= left_count;
			cur_r_q   <= -right_count;
			elapsed_q <= elapsed_us;
			ppr_q     <= {16'(pole_q) * 16'(gear_q), 2'b00};
			se_q      <= spacing_q * elapsed_us;
		end
		if (cmd.store) begin
			unique case (cmd.step)
				STEP_K: k_q <= prod[54:0];
				STEP_DL: begin
					if (ppr_q == 18'd0) dl_q <= '0;
					else dl_q <= tl[31] ? -$signed(prod[63:0]) : $signed(prod[63:0]);
				end
				STEP_DR: begin
					if (ppr_q == 18'd0) dr_q <= '0;
					else dr_q <= tr[31] ? -$signed(prod[63:0]) : $signed(prod[63:0]);
				end
				STEP_TH: begin
					if (spacing_zero) begin
						dth_q  <= '0;
						half_q <= '0;
					end else begin
						dth_q  <= diff[63] ? -prod[31:0] : prod[31:0];
						half_q <= diff[63] ? -prod[32:1] : prod[32:1];
					end
				end
				STEP_TURN: turn_q <= spacing_zero ? 32'd0 : sat32(prod, diff[63]);
				STEP_LIN:  lin_q  <= sat32(prod, sum[63]);
				STEP_MX:   stepx_q <= mvs;
				STEP_MY:   stepy_q <= mvs;
				default: ;
			endcase
		end
		if (cmd.cload) begin
			cx_q <= CORDIC_GAIN_Q30;
			cy_q <= '0;
			priority if (z0 > 34'sd1073741824) begin
				cz_q   <= z0 - 34'sd2147483648;
				flip_q <= 1'b1;
			end else if (z0 < -34'sd1073741824) begin
				cz_q   <= z0 + 34'sd2147483648;
				flip_q <= 1'b1;
			end else begin
				cz_q   <= z0;
				flip_q <= 1'b0;
			end
		end else if (cmd.crot) begin
			if (!cz_q[33]) begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				cz_q <= cz_q - at;
			end else begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				cz_q <= cz_q + at;
			end
		end
		if (cmd.commit) begin
			out_x_q    <= new_x;
			out_y_q    <= new_y;
			out_h_q    <= head_q + dth_q;
			out_lin_q  <= lin_q;
			out_turn_q <= turn_q;
		end
	end

	// pose and last counts are architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_x_q <= '0;
			pose_y_q <= '0;
			head_q   <= '0;
			last_l_q <= '0;
			last_r_q <= '0;
		end else if (cmd.take_clr) begin
			pose_x_q <= '0;
			pose_y_q <= '0;
			head_q   <= '0;
		end else if (cmd.commit) begin
			pose_x_q <= new_x;
			pose_y_q <= new_y;
			head_q   <= head_q + dth_q;
			last_l_q <= cur_l_q;
			last_r_q <= cur_r_q;
		end
	end

	assign pos_x_um          = out_x_q;
	assign pos_y_um          = out_y_q;
	assign heading_angle     = out_h_q;
	assign linear_speed_umps = out_lin_q;
	assign turn_rate_urads   = out_turn_q;

endmodule

// ----- src/diff_drive_odometry.sv -----
// Differential-drive odometry. An update transaction (command 0, elapsed_us not zero)
// occupies the block while one shared bit-serial unit runs eight products, five of them
// followed by a restoring division, each step with a load and a store state, and the
// heading CORDIC takes one rotation per cycle. in_stall is high for the whole update. A
// clear transaction, or an update with zero elapsed time, is taken without leaving the
// idle state and gives no result. A result held in the output register does not stop the
// next transaction from being taken; only the final write-back waits for the output to be
// free.
module diff_drive_odometry import odo_pkg::*; #(
	parameter int CORDIC_STAGES = 24,
	parameter int POSITION_BITS = 48
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [7:0]                      cfg_index,
	input  logic [21:0]                     cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            command,
	input  logic signed [31:0]              left_count,
	input  logic signed [31:0]              right_count,
	input  logic [23:0]                     elapsed_us,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [POSITION_BITS-1:0] pos_x_um,
	output logic signed [POSITION_BITS-1:0] pos_y_um,
	output logic signed [31:0]              heading_angle,
	output logic signed [31:0]              linear_speed_umps,
	output logic signed [31:0]              turn_rate_urads
);

	odo_cmd_t    cmd;
	odo_status_t status;

	odo_ctrl #(
		.CORDIC_STAGES (CORDIC_STAGES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	odo_datapath #(
		.POSITION_BITS (POSITION_BITS)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.command           (command),
		.left_count        (left_count),
		.right_count       (right_count),
		.elapsed_us        (elapsed_us),
		.cmd               (cmd),
		.status            (status),
		.pos_x_um          (pos_x_um),
		.pos_y_um          (pos_y_um),
		.heading_angle     (heading_angle),
		.linear_speed_umps (linear_speed_umps),
		.turn_rate_urads   (turn_rate_urads)
	);

endmodule

// ----- src/odo_checker.sv -----
module odo_checker #(
	parameter int POSITION_BITS = 48
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic                     command,
	input logic [23:0]              elapsed_us,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic [POSITION_BITS-1:0] pos_x_um
);

	// an update with time elapsed keeps the block busy
	a_upd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !command && elapsed_us != 24'd0) |=> in_stall)
		else $error("update transaction did not start work");

	// a clear transaction is taken and leaves the block idle
	a_clr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && command) |=> !in_stall)
		else $error("clear transaction left the block busy");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(pos_x_um)))
		else $error("stalled result changed or dropped");

	a_rose_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without work in progress");

	a_rose_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("block still busy after giving a result");

endmodule

bind diff_drive_odometry odo_checker #(
	.POSITION_BITS (POSITION_BITS)
) u_odo_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.command    (command),
	.elapsed_us (elapsed_us),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.pos_x_um   (pos_x_um)
);

// ----- tb/tb_diff_drive_odometry.sv -----
`timescale 1ns / 1ps

module tb_diff_drive_odometry;
	import odo_pkg::*;

	localparam int STAGES    = 24;
	localparam int POS_BITS  = 48;
	localparam int SETTLE    = 1400;
	localparam int STALL_MAX = 20000;

	typedef struct {
		logic              cmd;
		logic signed [31:0] left;
		logic signed [31:0] right;
		logic [23:0]       elapsed;
	} odo_txn_t;

	typedef struct {
		logic signed [47:0] x;
		logic signed [47:0] y;
		logic signed [31:0] heading;
		logic signed [31:0] lin;
		logic signed [31:0] turn;
	} pose_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [7:0] cfg_index = '0;
	logic [21:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic command = 1'b0;
	logic signed [31:0] left_count = '0;
	logic signed [31:0] right_count = '0;
	logic [23:0] elapsed_us = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [47:0] pos_x_um, pos_y_um;
	logic signed [31:0] heading_angle, linear_speed_umps, turn_rate_urads;

	diff_drive_odometry dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
		.command(command), .left_count(left_count), .right_count(right_count),
		.elapsed_us(elapsed_us), .out_valid(out_valid), .out_stall(out_stall),
		.pos_x_um(pos_x_um), .pos_y_um(pos_y_um), .heading_angle(heading_angle),
		.linear_speed_umps(linear_speed_umps), .turn_rate_urads(turn_rate_urads)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	odo_txn_t pending_q[$];
	pose_t    pose_q[$];
	int       send_idle_pct = 15;
	int       recv_idle_pct = 76;
	int       mismatches = 0;
	int       quiet_cycles = 0;

	// predictor copy of registers and state
	logic [7:0]  m_pole = POLE_RST;
	logic [7:0]  m_gear = GEAR_RST;
	logic [19:0] m_radius = RADIUS_RST;
	logic [21:0] m_spacing = SPACING_RST;
	logic [31:0] m_last_l = '0, m_last_r = '0, m_heading = '0;
	longint      m_x = 0, m_y = 0;

	function automatic logic [63:0] scaled_quot(input logic [63:0] a, input logic [63:0] b,
			input logic [63:0] c, output logic big);
		logic [127:0] q;
		q = ({64'd0, a} * {64'd0, b}) / {64'd0, c};
		big = |q[127:64];
		return q[63:0];
	endfunction

	function automatic logic [63:0] magn(input longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic longint apply_sign(input logic [63:0] m, input logic neg);
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic signed [31:0] clamp32(input logic [63:0] m, input logic big,
			input logic neg);
		if (neg)
			return (big || m > 64'd2147483648) ? 32'sh80000000 : 32'(-longint'(m));
		return (big || m > 64'd2147483647) ? 32'sh7fffffff : 32'(m);
	endfunction

	function automatic longint travel_um(input longint d, input longint f);
		logic big;
		logic [63:0] q;
		q = scaled_quot(magn(d), magn(f), 64'd1 << 30, big);
		return apply_sign((q + 64'd128) >> 8, (d < 0) != (f < 0));
	endfunction

	function automatic longint clamp_pos(input longint p, input longint d);
		longint hi, lo;
		hi = (longint'(1) <<< (POS_BITS - 1)) - 1;
		lo = -hi - 1;
		if (d > 0 && p > hi - d) return hi;
		if (d < 0 && p < lo - d) return lo;
		return p + d;
	endfunction

	// rotate the gain vector to the given binary angle
	task automatic rotate_unit(input logic [31:0] ang, output longint c, output longint s);
		logic signed [31:0] a32;
		longint z, x, y, xs, ys;
		logic flip;
		a32 = ang;
		z = a32;
		x = CORDIC_GAIN_Q30;
		y = 0;
		flip = 1'b0;
		if (z > 64'sd1073741824) begin
			z -= 64'sd2147483648;
			flip = 1'b1;
		end else if (z < -64'sd1073741824) begin
			z += 64'sd2147483648;
			flip = 1'b1;
		end
		for (int i = 0; i < STAGES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= longint'(ATAN_BA[i]);
			end else begin
				x += ys; y -= xs; z += longint'(ATAN_BA[i]);
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	task automatic advance_pose(input odo_txn_t t);
		logic [31:0] cur_l, cur_r, dth, half;
		logic signed [31:0] tl32, tr32;
		logic [63:0] ppr, kk, m, hm, el;
		longint dl, dr, sum, diff, dmean, cs, sn, turn, lin;
		logic big;
		pose_t p;
		if (t.cmd) begin
			m_x = 0; m_y = 0; m_heading = '0;
			return;
		end
		if (t.elapsed == 0)
			return;
		el = 64'(t.elapsed);
		cur_l = t.left;
		cur_r = 32'd0 - t.right;
		dl = 0; dr = 0; turn = 0;
		ppr = 64'(m_pole) * 64'(m_gear) * 64'd4;
		if (ppr != 0) begin
			kk = 64'(m_radius) * TWO_PI_Q32;
			tl32 = cur_l - m_last_l;
			tr32 = cur_r - m_last_r;
			dl = apply_sign(scaled_quot(magn(tl32), kk, ppr << 24, big), tl32 < 0);
			dr = apply_sign(scaled_quot(magn(tr32), kk, ppr << 24, big), tr32 < 0);
		end
		sum = dl + dr;
		diff = dr - dl;
		dmean = apply_sign(magn(sum) >> 1, sum < 0);
		dth = '0; half = '0;
		if (m_spacing != 0) begin
			m = scaled_quot(magn(diff), INV_PI_Q32, 64'(m_spacing) << 9, big);
			hm = m >> 1;
			dth = diff < 0 ? 32'(64'd0 - m) : m[31:0];
			half = diff < 0 ? 32'(64'd0 - hm) : hm[31:0];
			m = scaled_quot(magn(diff), TERA, 64'(m_spacing) * el * 64'd256, big);
			turn = clamp32(m, big, diff < 0);
		end
		m = scaled_quot(magn(sum), MEGA, el << 9, big);
		lin = clamp32(m, big, sum < 0);
		rotate_unit(m_heading + half, cs, sn);
		m_x = clamp_pos(m_x, travel_um(dmean, cs));
		m_y = clamp_pos(m_y, travel_um(dmean, sn));
		m_heading += dth;
		m_last_l = cur_l;
		m_last_r = cur_r;
		p.x = m_x[47:0];
		p.y = m_y[47:0];
		p.heading = m_heading;
		p.lin = lin[31:0];
		p.turn = turn[31:0];
		pose_q.insert(pose_q.size(), p);
	endtask

	// driver
	always @(posedge clk) begin
		odo_txn_t nxt;
		logic take;
		if (arst_n) begin
			take = !in_valid;
			if (in_valid && !in_stall) begin
				advance_pose('{command, left_count, right_count, elapsed_us});
				take = 1'b1;
			end
			if (take) begin
				if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_q.pop_front();
					in_valid <= 1'b1;
					command <= nxt.cmd;
					left_count <= nxt.left;
					right_count <= nxt.right;
					elapsed_us <= nxt.elapsed;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		pose_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pose_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result x=%0d y=%0d", pos_x_um, pos_y_um);
				end else begin
					e = pose_q.pop_front();
					if (pos_x_um !== e.x || pos_y_um !== e.y || heading_angle !== e.heading ||
							linear_speed_umps !== e.lin || turn_rate_urads !== e.turn) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch exp x=%0d y=%0d h=%0d v=%0d w=%0d got %0d %0d %0d %0d %0d",
								e.x, e.y, e.heading, e.lin, e.turn, pos_x_um, pos_y_um,
								heading_angle, linear_speed_umps, turn_rate_urads);
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_MAX) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	logic signed [31:0] gen_l = '0, gen_r = '0;

	task automatic queue_txn(input logic cmd, input logic signed [31:0] l,
			input logic signed [31:0] r, input logic [23:0] el);
		odo_txn_t t;
		t = '{cmd, l, r, el};
		pending_q.insert(pending_q.size(), t);
		gen_l = l;
		gen_r = r;
	endtask

	task automatic wait_drained();
		do begin
			@(posedge clk);
			#1;
		end while (pending_q.size() != 0 || in_valid || pose_q.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [21:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_POLE:    m_pole = val[7:0];
			CFG_GEAR:    m_gear = val[7:0];
			CFG_RADIUS:  m_radius = val[19:0];
			CFG_SPACING: m_spacing = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic random_txns(input int n);
		int r;
		logic [23:0] el;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			el = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(20000, 1));
			if (r < 5)
				queue_txn(1'b1, $urandom, $urandom, 24'($urandom));
			else if (r < 10)
				queue_txn(1'b0, $urandom, $urandom, 24'd0);
			else if (r < 18)
				queue_txn(1'b0, $urandom, $urandom, el);
			else
				queue_txn(1'b0, gen_l + $signed(32'($urandom_range(4000)) - 32'sd2000),
					gen_r + $signed(32'($urandom_range(4000)) - 32'sd2000), el);
			if (i == n / 2) begin
				// hold the sender back until everything has come out
				do begin
					@(posedge clk);
					#1;
				end while (pending_q.size() != 0 || in_valid || pose_q.size() != 0);
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		queue_txn(1'b0, 32'sd100, -32'sd100, 24'd10000);
		queue_txn(1'b0, 32'sd300, -32'sd250, 24'd1);
		queue_txn(1'b0, 32'sd300, -32'sd250, 24'd0);
		queue_txn(1'b1, 32'sd5, 32'sd5, 24'd5);
		queue_txn(1'b0, 32'sh7fffffff, 32'sh80000000, 24'hffffff);
		queue_txn(1'b0, 32'sh80000000, 32'sh7fffffff, 24'd1);
		queue_txn(1'b0, -32'sd1, 32'sd1, 24'd1000);
		queue_txn(1'b0, 32'sd0, 32'sd0, 24'd1);
		queue_txn(1'b0, 32'sd2000, 32'sd2000, 24'd10000);
		queue_txn(1'b0, -32'sd2000, -32'sd2000, 24'd10000);
		queue_txn(1'b0, 32'sd40000, -32'sd40000, 24'd10000);
		queue_txn(1'b0, 32'sd80000, -32'sd80000, 24'd10000);
		queue_txn(1'b0, 32'sd80000, -32'sd80000, 24'hffffff);
		queue_txn(1'b1, 32'sd0, 32'sd0, 24'd0);
		queue_txn(1'b0, 32'sd80500, -32'sd79500, 24'h800000);
		random_txns(60);
		wait_drained();

		// coarsest scale, huge steps to push position into saturation
		write_reg(CFG_POLE, 22'd1);
		write_reg(CFG_GEAR, 22'd1);
		write_reg(CFG_RADIUS, 22'hfffff);
		write_reg(CFG_SPACING, 22'd1);
		write_reg(8'd7, 22'd123);
		queue_txn(1'b0, 32'sh7fffffff, 32'sh80000001, 24'd1);
		queue_txn(1'b0, 32'sh7ffffffe, 32'sh80000002, 24'd1);
		queue_txn(1'b0, -32'sd2, 32'sd2, 24'd1);
		queue_txn(1'b0, 32'sh7ffffffe, 32'sh80000002, 24'd1);
		random_txns(60);
		wait_drained();

		send_idle_pct = 76;
		recv_idle_pct = 15;
		write_reg(CFG_POLE, 22'd255);
		write_reg(CFG_GEAR, 22'd255);
		write_reg(CFG_RADIUS, 22'd1);
		write_reg(CFG_SPACING, 22'h3fffff);
		random_txns(70);
		wait_drained();

		// zero pole: no travel; zero spacing: no turning
		write_reg(CFG_POLE, 22'd0);
		write_reg(CFG_RADIUS, 22'd50000);
		write_reg(CFG_SPACING, 22'd0);
		random_txns(50);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(CFG_POLE, 22'd12);
		write_reg(CFG_GEAR, 22'd0);
		random_txns(40);
		wait_drained();

		write_reg(CFG_GEAR, 22'd20);
		write_reg(CFG_RADIUS, 22'd80000);
		write_reg(CFG_SPACING, 22'd400000);
		random_txns(200);
		wait_drained();

		if (mismatches == 0 && pose_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
